// ===== rtl/assert_macros.svh =====
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/puc_pkg.sv =====
// package for the particle update core: sizes, codes and state type
`default_nettype none
package puc_pkg;
  localparam int MaxParticles = 64;
  localparam int IdxW = $clog2(MaxParticles);
  localparam int CntW = $clog2(MaxParticles + 1);
  localparam logic [15:0] FadeHeight = 16'd40;
  localparam logic [7:0] AlphaFull = 8'd255;
  // fade height in q16.16, the span over which height alpha ramps up
  localparam logic signed [32:0] FadeSpan = $signed({1'b0, FadeHeight, 16'd0});
  // ceil(2^16 / 5), exact floor division by 5 for values below 2^14
  localparam logic [13:0] RecipFive = 14'd13108;

  localparam logic FUNC_SPAWN = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_FLOOR = 3'd1;
  localparam logic [2:0] REG_LIFE = 3'd2;
  localparam logic [2:0] REG_AX = 3'd3;
  localparam logic [2:0] REG_AY = 3'd4;
  localparam logic [2:0] REG_COLOR = 3'd5;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_READ  = 12'b000000000010,
    S_LOAD  = 12'b000000000100,
    S_VX    = 12'b000000001000,
    S_VY    = 12'b000000010000,
    S_PX    = 12'b000000100000,
    S_PY    = 12'b000001000000,
    S_APREP = 12'b000010000000,
    S_DIV   = 12'b000100000000,
    S_WRITE = 12'b001000000000,
    S_EMIT  = 12'b010000000000,
    S_NONE  = 12'b100000000000
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/particle_update_compact_core.sv =====
// top level of the particle update core: table, sequencer and shared multiply/divide
//
// particle table with compacting euler update, q16.16 fixed point
// channels: cfg (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the six
//   registers; in (in_valid/in_ready) takes one word: func 0 spawns a
//   particle, func 1 runs a tick; out (out_valid/out_ready) gives one word per
//   surviving particle, last set on the final one
// a spawn is taken while idle and gives no word; in_ready stays high
// a tick walks the table one particle at a time; a dead particle passes read
//   and load only, a live one also four steps on the one shared 32x16
//   multiplier, then alpha, write and emit, where output stalls can hold it;
//   in time mode alpha adds a 42-step restoring divider unless age is negative
// each survivor is held until the next one is known, so a word leaves one
//   survivor late and the final word goes out when the walk ends
// the divider gives one quotient bit per cycle; in_ready is low during a tick
// a tick that leaves no survivor gives one none_alive word
// when out_ready is low the sequencer waits holding the word; the table
//   update for that particle is already written
// reset clears the registers to their defaults and empties the table; the
//   table memory itself is not cleared, only live_count gates reads
// cfg is ready only while the block is idle and no input word is offered
`default_nettype none
module particle_update_compact_core import puc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_y,
  input  wire logic signed [31:0] in_vx,
  input  wire logic signed [31:0] in_vy,
  input  wire logic [31:0] now,
  input  wire logic [15:0] dt,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [7:0]       alpha,
  output logic [23:0]      color,
  output logic             none_alive,
  output logic             last
);
  // configuration registers
  logic        expire_by_time;
  logic signed [31:0] floor_y;
  logic [31:0] lifetime;
  logic signed [31:0] accel_x, accel_y;
  logic [23:0] spawn_color;

  // particle table, one memory per field, written and read in one clocked block
  logic [31:0] mem_x [MaxParticles];
  logic [31:0] mem_y [MaxParticles];
  logic [31:0] mem_vx [MaxParticles];
  logic [31:0] mem_vy [MaxParticles];
  logic [31:0] mem_b [MaxParticles];
  logic [23:0] mem_c [MaxParticles];

  state_t state;
  logic [CntW-1:0] live_count, rd_idx, kept;
  logic [31:0] tick_now;
  logic [15:0] tick_dt;

  // read data registers
  logic signed [31:0] rx, ry, rvx, rvy;
  logic [31:0] rb;
  logic [23:0] rc;

  // working registers
  logic signed [31:0] vx, vy, px, py;
  logic signed [32:0] age;
  logic [7:0] a_val;
  logic [5:0] div_cnt;
  logic [41:0] div_rem;
  logic [41:0] div_quo;
  logic [41:0] div_den;
  logic use_div, use_fade;
  logic [10:0] fade_v;

  // survivor held until the next one is known, so that last is right
  logic hold_valid;
  logic signed [31:0] hold_x, hold_y;
  logic [7:0] hold_a;
  logic [23:0] hold_c;

  // memory write port
  logic wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [31:0] wx, wy, wvx, wvy, wb;
  logic [23:0] wc;

  assign cfg_ready = (state == S_IDLE) && !in_valid;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wx;
      mem_y[wr_addr] <= wy;
      mem_vx[wr_addr] <= wvx;
      mem_vy[wr_addr] <= wvy;
      mem_b[wr_addr] <= wb;
      mem_c[wr_addr] <= wc;
    end
    rx <= mem_x[rd_idx[IdxW-1:0]];
    ry <= mem_y[rd_idx[IdxW-1:0]];
    rvx <= mem_vx[rd_idx[IdxW-1:0]];
    rvy <= mem_vy[rd_idx[IdxW-1:0]];
    rb <= mem_b[rd_idx[IdxW-1:0]];
    rc <= mem_c[rd_idx[IdxW-1:0]];
  end

  // shared multiplier: rate * dt, floored shift by 16, added to base, saturated
  logic signed [31:0] mul_rate, mul_base, adv;
  logic signed [48:0] prod;
  logic signed [33:0] sum;
  always_comb begin
    mul_rate = rx;
    mul_base = rx;
    case (state)
      S_VX: begin mul_rate = accel_x; mul_base = rvx; end
      S_VY: begin mul_rate = accel_y; mul_base = rvy; end
      S_PX: begin mul_rate = vx; mul_base = rx; end
      S_PY: begin mul_rate = vy; mul_base = ry; end
      default: begin mul_rate = rx; mul_base = rx; end
    endcase
    prod = 49'(mul_rate) * $signed({33'd0, tick_dt});
    sum = 34'(mul_base) + 34'(prod >>> 16);
    if (sum > 34'sd2147483647) adv = 32'sh7fffffff;
    else if (sum < -34'sd2147483648) adv = 32'sh80000000;
    else adv = sum[31:0];
  end

  // alive test on the freshly read entry
  logic signed [32:0] age_now;
  logic alive;
  always_comb begin
    age_now = $signed({1'b0, tick_now}) - $signed({1'b0, rb});
    if (expire_by_time) alive = age_now < $signed({1'b0, lifetime});
    else alive = ry > floor_y;
  end

  // divider step
  logic [42:0] trial;
  assign trial = {div_rem, div_quo[41]} - {1'b0, div_den};

  logic signed [32:0] dy;
  assign dy = 33'(py) - 33'(floor_y);

  // height alpha below the fade span: floor(dy * 255 / 2^19), then / 5
  logic [29:0] fade_prod;
  assign fade_prod = 30'(dy[21:0]) * 30'(AlphaFull);

  // final alpha of the current survivor
  logic [24:0] fade_mul;
  logic [7:0] alpha_fin;
  always_comb begin
    fade_mul = 25'(fade_v) * 25'(RecipFive);
    if (use_div) alpha_fin = (div_quo[41:8] != '0) ? AlphaFull : div_quo[7:0];
    else if (use_fade) alpha_fin = fade_mul[23:16];
    else alpha_fin = a_val;
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = kept[IdxW-1:0];
    wx = px; wy = py; wvx = vx; wvy = vy; wb = rb; wc = rc;
    if (state == S_IDLE && in_valid && func == FUNC_SPAWN && live_count < CntW'(MaxParticles)) begin
      wr_en = 1'b1;
      wr_addr = live_count[IdxW-1:0];
      wx = in_x; wy = in_y; wvx = in_vx; wvy = in_vy; wb = now; wc = spawn_color;
    end else if (state == S_WRITE) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      live_count <= '0;
      rd_idx <= '0;
      kept <= '0;
      out_valid <= 1'b0;
      hold_valid <= 1'b0;
      expire_by_time <= 1'b0;
      floor_y <= '0;
      lifetime <= 32'd65536;
      accel_x <= '0;
      accel_y <= '0;
      spawn_color <= 24'hffffff;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            case (cfg_index)
              REG_MODE: expire_by_time <= cfg_data[0];
              REG_FLOOR: floor_y <= cfg_data;
              REG_LIFE: lifetime <= cfg_data;
              REG_AX: accel_x <= cfg_data;
              REG_AY: accel_y <= cfg_data;
              REG_COLOR: spawn_color <= cfg_data[23:0];
              default: ;
            endcase
          end
          if (in_valid) begin
            if (func == FUNC_SPAWN) begin
              if (live_count < CntW'(MaxParticles)) live_count <= live_count + 1'b1;
            end else begin
              tick_now <= now;
              tick_dt <= dt;
              rd_idx <= '0;
              kept <= '0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // address in rd_idx is presented; data lands next cycle
          if (rd_idx >= live_count) begin
            live_count <= kept;
            if (kept == '0) begin
              out_x <= '0; out_y <= '0; alpha <= '0; color <= '0;
              none_alive <= 1'b1; last <= 1'b1; out_valid <= 1'b1;
            end else begin
              // the held survivor is the final word of the tick
              out_x <= hold_x; out_y <= hold_y; alpha <= hold_a; color <= hold_c;
              none_alive <= 1'b0; last <= 1'b1; out_valid <= 1'b1;
            end
            hold_valid <= 1'b0;
            state <= S_NONE;
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          age <= age_now;
          if (alive) state <= S_VX;
          else begin
            rd_idx <= rd_idx + 1'b1;
            state <= S_READ;
          end
        end
        S_VX: begin vx <= adv; state <= S_VY; end
        S_VY: begin vy <= adv; state <= S_PX; end
        S_PX: begin px <= adv; state <= S_PY; end
        S_PY: begin py <= adv; state <= S_APREP; end
        S_APREP: begin
          div_cnt <= '0;
          div_rem <= '0;
          if (expire_by_time) begin
            if (age[32]) begin
              a_val <= AlphaFull;
              use_div <= 1'b0;
              use_fade <= 1'b0;
              state <= S_WRITE;
            end else begin
              // (lifetime - age) is in 1..lifetime, so quotient stays <= 255
              div_quo <= 42'(33'(lifetime) - age) * 42'(AlphaFull);
              div_den <= 42'(lifetime);
              use_div <= 1'b1;
              use_fade <= 1'b0;
              state <= S_DIV;
            end
          end else if (dy[32] || dy == '0) begin
            a_val <= '0;
            use_div <= 1'b0;
            use_fade <= 1'b0;
            state <= S_WRITE;
          end else if (dy >= FadeSpan) begin
            a_val <= AlphaFull;
            use_div <= 1'b0;
            use_fade <= 1'b0;
            state <= S_WRITE;
          end else begin
            fade_v <= fade_prod[29:19];
            use_div <= 1'b0;
            use_fade <= 1'b1;
            state <= S_WRITE;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          if (trial[42]) div_rem <= {div_rem[40:0], div_quo[41]};
          else div_rem <= trial[41:0];
          div_quo <= {div_quo[40:0], ~trial[42]};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 6'd41) state <= S_WRITE;
        end
        S_WRITE: begin
          // the previous survivor is now known not to be the last
          if (hold_valid) begin
            out_x <= hold_x; out_y <= hold_y; alpha <= hold_a; color <= hold_c;
            none_alive <= 1'b0; last <= 1'b0; out_valid <= 1'b1;
          end
          hold_valid <= 1'b1;
          hold_x <= px; hold_y <= py; hold_a <= alpha_fin; hold_c <= rc;
          kept <= kept + 1'b1;
          rd_idx <= rd_idx + 1'b1;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b0;
            state <= S_READ;
          end
        end
        S_NONE: begin
          // final word of the tick, none_alive or the last survivor
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/puc_checker.sv =====
// port checker for the particle update core and its bind
`default_nettype none
`include "assert_macros.svh"
module puc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic cfg_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic none_alive,
  input wire logic last,
  input wire logic [7:0] alpha
);
  `ASSERT_NEXT(out_hold, clk, rst, out_valid && !out_ready, out_valid, "out word dropped")
  `ASSERT_IMPL(busy_when_out, clk, rst, out_valid, !in_ready, "input taken while output pending")
  `ASSERT_IMPL(cfg_only_idle, clk, rst, cfg_ready, in_ready, "cfg ready outside idle")
  `ASSERT_IMPL(none_is_last, clk, rst, out_valid && none_alive, last && alpha == 8'd0, "bad none word")
endmodule
bind particle_update_compact_core puc_checker u_puc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .cfg_ready(cfg_ready), .out_valid(out_valid), .out_ready(out_ready),
  .none_alive(none_alive), .last(last), .alpha(alpha)
);
`default_nettype wire

// ===== tb/particle_checker.sv =====
// scoreboard for the particle update core: tracks config, predicts each tick, compares words
`default_nettype none
module particle_checker import puc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        func,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_y,
  input  wire logic signed [31:0] in_vx,
  input  wire logic signed [31:0] in_vy,
  input  wire logic [31:0] now,
  input  wire logic [15:0] dt,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic signed [31:0] out_x,
  input  wire logic signed [31:0] out_y,
  input  wire logic [7:0]  alpha,
  input  wire logic [23:0] color,
  input  wire logic        none_alive,
  input  wire logic        last,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [7:0]         a;
    logic [23:0]        c;
    logic               none;
    logic               fin;
  } particle_word_t;

  particle_word_t expected_words[$];

  logic               by_age;
  logic signed [31:0] floor_h;
  logic [31:0]        life;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic [23:0]        new_color;

  logic signed [31:0] px[MaxParticles];
  logic signed [31:0] py[MaxParticles];
  logic signed [31:0] pvx[MaxParticles];
  logic signed [31:0] pvy[MaxParticles];
  logic [31:0]        pborn[MaxParticles];
  logic [23:0]        pcol[MaxParticles];
  int                 n_live;

  // base + floor(rate * dt / 2^16), saturated to 32 bits
  function automatic logic signed [31:0] euler_step(logic signed [31:0] base,
                                                    logic signed [31:0] rate,
                                                    logic [15:0] step);
    longint prod;
    longint sum;
    prod = longint'(rate) * longint'({16'b0, step});
    sum = longint'(base) + (prod >>> 16);
    if (sum > 64'sd2147483647) return 32'sh7fffffff;
    if (sum < -64'sd2147483648) return 32'sh80000000;
    return sum[31:0];
  endfunction

  function automatic logic [7:0] clamp8(longint v);
    if (v < 0) return 8'd0;
    if (v > 255) return AlphaFull;
    return v[7:0];
  endfunction

  task automatic run_tick(logic [31:0] t, logic [15:0] step);
    int kept;
    longint age;
    longint d;
    logic ok;
    logic signed [31:0] vx, vy, x, y;
    logic [7:0] a;
    particle_word_t w;
    kept = 0;
    for (int i = 0; i < n_live; i++) begin
      age = longint'({32'b0, t}) - longint'({32'b0, pborn[i]});
      ok = by_age ? (age < longint'({32'b0, life})) : (py[i] > floor_h);
      if (!ok) continue;
      vx = euler_step(pvx[i], acc_x, step);
      vy = euler_step(pvy[i], acc_y, step);
      x = euler_step(px[i], vx, step);
      y = euler_step(py[i], vy, step);
      if (by_age) begin
        if (age < 0) a = AlphaFull;
        else a = clamp8(((longint'({32'b0, life}) - age) * 255) / longint'({32'b0, life}));
      end else begin
        d = longint'(y) - longint'(floor_h);
        if (d <= 0) a = 8'd0;
        else a = clamp8((d * 255) / (longint'(FadeHeight) * 65536));
      end
      px[kept] = x;
      py[kept] = y;
      pvx[kept] = vx;
      pvy[kept] = vy;
      pborn[kept] = pborn[i];
      pcol[kept] = pcol[i];
      w.x = x; w.y = y; w.a = a; w.c = pcol[i]; w.none = 1'b0; w.fin = 1'b0;
      expected_words.push_back(w);
      kept++;
    end
    n_live = kept;
    if (kept == 0) begin
      w.x = '0; w.y = '0; w.a = '0; w.c = '0; w.none = 1'b1; w.fin = 1'b1;
      expected_words.push_back(w);
    end else begin
      expected_words[expected_words.size() - 1].fin = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    particle_word_t e;
    if (rst) begin
      by_age = 1'b0;
      floor_h = '0;
      life = 32'd65536;
      acc_x = '0;
      acc_y = '0;
      new_color = 24'hffffff;
      n_live = 0;
      errors = 0;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:  by_age = cfg_data[0];
          REG_FLOOR: floor_h = cfg_data;
          REG_LIFE:  life = cfg_data;
          REG_AX:    acc_x = cfg_data;
          REG_AY:    acc_y = cfg_data;
          REG_COLOR: new_color = cfg_data[23:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (func == FUNC_SPAWN) begin
          // full table drops the spawn
          if (n_live < MaxParticles) begin
            px[n_live] = in_x;
            py[n_live] = in_y;
            pvx[n_live] = in_vx;
            pvy[n_live] = in_vy;
            pborn[n_live] = now;
            pcol[n_live] = new_color;
            n_live++;
          end
        end else begin
          run_tick(now, dt);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          if (errors < 10) $display("checker: unexpected word x=%0d y=%0d", out_x, out_y);
          errors++;
        end else begin
          e = expected_words.pop_front();
          if (out_x !== e.x || out_y !== e.y || alpha !== e.a || color !== e.c ||
              none_alive !== e.none || last !== e.fin) begin
            if (errors < 10) begin
              $display("checker: exp x=%0d y=%0d a=%0d c=%h none=%b last=%b",
                       e.x, e.y, e.a, e.c, e.none, e.fin);
              $display("checker: got x=%0d y=%0d a=%0d c=%h none=%b last=%b",
                       out_x, out_y, alpha, color, none_alive, last);
            end
            errors++;
          end
        end
      end
    end
    pending = expected_words.size();
  end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// testbench top for the particle update core: stimulus, watchdog and verdict
`default_nettype none
module tb;
  import puc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;
  localparam int Drain = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic signed [31:0] in_x = '0;
  logic signed [31:0] in_y = '0;
  logic signed [31:0] in_vx = '0;
  logic signed [31:0] in_vy = '0;
  logic [31:0] now = '0;
  logic [15:0] dt = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic [7:0] alpha;
  logic [23:0] color;
  logic none_alive;
  logic last;

  int errors;
  int pending;
  bit calm = 1'b0;           // no idling on either side in the last phase
  logic [31:0] sim_clock = '0; // running q16.16 time handed to the block
  logic by_age;
  logic signed [31:0] floor_h;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  particle_update_compact_core uut (.*);

  particle_checker checker_i (.*);

  // output side stalls in random bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (calm || rst) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: cycles with no word moving on any channel
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= IdleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold off until the table walk is finished and the block is idle again
  task automatic drain_out();
    in_valid <= 1'b0;
    // the checker counts a tick at its accepting edge; let that settle first
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic configure(logic mode, logic signed [31:0] fl, logic [31:0] life,
                           logic signed [31:0] ax, logic signed [31:0] ay, logic [23:0] col);
    drain_out();
    write_reg(REG_MODE, {31'b0, mode});
    write_reg(REG_FLOOR, fl);
    write_reg(REG_LIFE, life);
    write_reg(REG_AX, ax);
    write_reg(REG_AY, ay);
    write_reg(REG_COLOR, {8'b0, col});
    by_age = mode;
    floor_h = fl;
  endtask

  // one input word, then maybe a random gap
  task automatic put(logic f, logic signed [31:0] x, logic signed [31:0] y,
                     logic signed [31:0] vx, logic signed [31:0] vy,
                     logic [31:0] t, logic [15:0] step);
    func <= f;
    in_x <= x;
    in_y <= y;
    in_vx <= vx;
    in_vy <= vy;
    now <= t;
    dt <= step;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic spawn(logic signed [31:0] x, logic signed [31:0] y,
                       logic signed [31:0] vx, logic signed [31:0] vy);
    put(FUNC_SPAWN, x, y, vx, vy, sim_clock, 16'($urandom));
  endtask

  task automatic tick(logic [15:0] step);
    sim_clock = sim_clock + step;
    put(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, sim_clock, step);
  endtask

  function automatic logic signed [31:0] small_val();
    return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
  endfunction

  // spawn height that survives the floor test when possible
  function automatic logic signed [31:0] above_floor();
    longint v;
    v = longint'(floor_h) + 1 + $urandom_range(0, 32'h7fffff);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return '0;
      3: return small_val();
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int items, int spawn_pct);
    int r;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        // noise: any field, any time, including ages below zero
        put(FUNC_SPAWN + 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
            $urandom, $urandom, 16'($urandom));
      end else if (r < 12 + spawn_pct) begin
        if ($urandom_range(0, 3) == 0)
          spawn($urandom, $urandom, $urandom, $urandom);
        else
          spawn(small_val() <<< 8, by_age ? small_val() : above_floor(),
                small_val(), small_val());
      end else begin
        tick(16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 16'h3fff)));
      end
    end
  endtask

  initial begin
    by_age = 1'b0;
    floor_h = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: height mode, floor 0; empty table gives a none-alive word
    tick(16'd100);
    spawn(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    spawn(32'sh7fffffff, 32'sd1, 32'sh80000000, 32'sh80000000);
    spawn(32'sd5, 32'sd0, 32'sd0, 32'sd0);          // exactly on the floor, dies
    spawn(32'sd5, -32'sd1, 32'sd0, 32'sd0);
    tick(16'd0);
    tick(16'hffff);
    drain_out();

    // extreme acceleration drives saturation
    configure(1'b0, 32'sh80000000, 32'd1, 32'sh7fffffff, 32'sh80000000, 24'h000000);
    spawn(32'sh7fff0000, 32'sh7fff0000, 32'sh7fffffff, 32'sh80000000);
    spawn(32'sh80000000, 32'sh80000001, 32'sh80000000, 32'sh7fffffff);
    tick(16'hffff);
    tick(16'hffff);

    // time mode, lifetime one tick of q16.16: age zero lives, age one dies
    configure(1'b1, 32'sh7fffffff, 32'd1, 32'sd0, 32'sd0, 24'hffffff);
    sim_clock = 32'd1000;
    spawn(32'sd0, 32'sd0, 32'sd65536, 32'sd0);
    tick(16'd0);
    tick(16'd1);
    // negative age: tick time earlier than birth
    spawn(32'sd1, 32'sd2, 32'sd3, 32'sd4);
    put(FUNC_TICK, '0, '0, '0, '0, 32'd10, 16'd5);

    configure(1'b1, '0, 32'hffffffff, small_val(), small_val(), 24'h123456);
    put(FUNC_SPAWN, 32'sd7, 32'sd7, 32'sd7, 32'sd7, 32'hffffffff, 16'd0);
    put(FUNC_TICK, '0, '0, '0, '0, 32'h0, 16'd1);
    put(FUNC_TICK, '0, '0, '0, '0, 32'hffffffff, 16'd1);

    // random phases with varied settings; the last one runs without idling
    for (int p = 0; p < 8; p++) begin
      if (p == 7) begin
        drain_out();
        calm = 1'b1;
      end
      sim_clock = $urandom;
      if (p % 2 == 0)
        configure(1'b0, (p == 4) ? 32'sh7fffffff : (p == 2 ? 32'sh80000000 : small_val()),
                  $urandom, pick_extreme(), pick_extreme(), 24'($urandom));
      else
        configure(1'b1, $urandom,
                  (p == 3) ? 32'hffffffff : 32'($urandom_range(1, 32'h1fffff)),
                  pick_extreme(), pick_extreme(), 24'($urandom));
      // spawn-heavy phases fill the table past its size
      random_phase(50, (p == 2 || p == 5) ? 80 : 55);
    end

    drain_out();
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/puc_pkg.sv
rtl/particle_update_compact_core.sv
rtl/puc_checker.sv
tb/particle_checker.sv
tb/tb.sv
